// ----- hdl/bcs_pkg.sv -----
package bcs_pkg;

	localparam int POS_W  = 21;
	localparam int DIST_W = 22;
	localparam int SPD_W  = 16;
	localparam int FEED_W = 13;
	localparam int STEP_W = 11;
	localparam int LEN_W  = 20;

	localparam int TOLERANCE_UM = 10;
	localparam int BACKOFF_UM   = 200;

	localparam logic [FEED_W-1:0] FEED_MIN = FEED_W'(100);
	localparam logic [FEED_W-1:0] FEED_MAX = FEED_W'(5000);
	localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(50);
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(2000);

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] REG_FEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Z_RAPID = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_X_RAPID = 3'd5;

	// commands
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	// run modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_PAUSED = 2'd1;
	localparam logic [1:0] MODE_ACTIVE = 2'd2;

	// cycle phases
	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_SYNC      = 4'd1;
	localparam logic [3:0] PH_HOME_Z    = 4'd2;
	localparam logic [3:0] PH_HOME_X    = 4'd3;
	localparam logic [3:0] PH_PLUNGE    = 4'd4;
	localparam logic [3:0] PH_BACKOFF   = 4'd5;
	localparam logic [3:0] PH_RETRACT   = 4'd6;
	localparam logic [3:0] PH_RESTORE   = 4'd7;
	localparam logic [3:0] PH_STEP_IN   = 4'd8;
	localparam logic [3:0] PH_REPLUNGE  = 4'd9;
	localparam logic [3:0] PH_FINISH    = 4'd10;
	localparam logic [3:0] PH_DONE      = 4'd11;

	typedef struct packed {
		logic [FEED_W-1:0] feed;
		logic [STEP_W-1:0] step;
		logic [LEN_W-1:0]  depth;
		logic [LEN_W-1:0]  width;
		logic [SPD_W-1:0]  z_rapid;
		logic [SPD_W-1:0]  x_rapid;
	} cfg_t;

	// declared highest bits first so the cast from tdata puts command lowest
	typedef struct packed {
		logic signed [POS_W-1:0] x_position;
		logic signed [POS_W-1:0] z_position;
		logic                    x_moving;
		logic                    z_moving;
		logic                    spindle_at_index;
		logic                    spindle_turning;
		logic [1:0]              command;
	} item_t;

	typedef struct packed {
		logic                     start_rejected;
		logic [3:0]               cycle_phase;
		logic [1:0]               run_mode;
		logic                     sync_request;
		logic                     move_constant_speed;
		logic [SPD_W-1:0]         move_speed;
		logic signed [DIST_W-1:0] move_distance;
		logic                     move_axis;
		logic                     move_valid;
	} result_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic [3:0]              phase;
		logic                    save_x;
		logic signed [POS_W-1:0] saved_x;
	} state_upd_t;

endpackage

// ----- hdl/bcs_cfg_regs.sv -----
module bcs_cfg_regs import bcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;
	logic [FEED_W-1:0] feed_in;
	logic [STEP_W-1:0] step_in;
	logic [FEED_W-1:0] feed_clamped;
	logic [STEP_W-1:0] step_clamped;

	// only clamped values are ever used, so clamp on the way in
	assign feed_in = cfg_data[FEED_W-1:0];
	assign step_in = cfg_data[STEP_W-1:0];
	assign feed_clamped = (feed_in < FEED_MIN) ? FEED_MIN :
		(feed_in > FEED_MAX) ? FEED_MAX : feed_in;
	assign step_clamped = (step_in < STEP_MIN) ? STEP_MIN :
		(step_in > STEP_MAX) ? STEP_MAX : step_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.feed    <= FEED_W'(1000);
			cfg_q.step    <= STEP_W'(100);
			cfg_q.depth   <= LEN_W'(2000);
			cfg_q.width   <= LEN_W'(500);
			cfg_q.z_rapid <= SPD_W'(5000);
			cfg_q.x_rapid <= SPD_W'(5000);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FEED:    cfg_q.feed    <= feed_clamped;
				REG_STEP:    cfg_q.step    <= step_clamped;
				REG_DEPTH:   cfg_q.depth   <= cfg_data[LEN_W-1:0];
				REG_WIDTH:   cfg_q.width   <= cfg_data[LEN_W-1:0];
				REG_Z_RAPID: cfg_q.z_rapid <= cfg_data[SPD_W-1:0];
				REG_X_RAPID: cfg_q.x_rapid <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/bcs_phase_logic.sv -----
module bcs_phase_logic import bcs_pkg::*; (
	input  cfg_t                    cfg,
	input  item_t                   item,
	input  logic [1:0]              mode_cur,
	input  logic [3:0]              phase_cur,
	input  logic signed [POS_W-1:0] saved_x_cur,
	output state_upd_t              upd,
	output result_t                 res
);

	logic signed [DIST_W-1:0] z_ext;
	logic signed [DIST_W-1:0] x_ext;
	logic signed [DIST_W-1:0] sx_ext;
	logic signed [DIST_W-1:0] depth_ext;
	logic signed [DIST_W-1:0] width_ext;
	logic signed [DIST_W-1:0] step_ext;
	logic signed [DIST_W-1:0] rem;
	logic [SPD_W-1:0]         feed_spd;
	logic [SPD_W-1:0]         half_feed_spd;
	logic                     z_off_home;
	logic                     x_off_home;
	logic                     width_left;

	assign z_ext     = {item.z_position[POS_W-1], item.z_position};
	assign x_ext     = {item.x_position[POS_W-1], item.x_position};
	assign sx_ext    = {saved_x_cur[POS_W-1], saved_x_cur};
	assign depth_ext = {{(DIST_W-LEN_W){1'b0}}, cfg.depth};
	assign width_ext = {{(DIST_W-LEN_W){1'b0}}, cfg.width};
	assign step_ext  = {{(DIST_W-STEP_W){1'b0}}, cfg.step};
	assign rem       = width_ext - x_ext;
	assign feed_spd      = {{(SPD_W-FEED_W){1'b0}}, cfg.feed};
	assign half_feed_spd = {{(SPD_W-FEED_W+1){1'b0}}, cfg.feed[FEED_W-1:1]};

	assign z_off_home = (z_ext > DIST_W'(TOLERANCE_UM)) || (z_ext < -DIST_W'(TOLERANCE_UM));
	assign x_off_home = (x_ext > DIST_W'(TOLERANCE_UM)) || (x_ext < -DIST_W'(TOLERANCE_UM));
	assign width_left = (x_ext + DIST_W'(TOLERANCE_UM)) < width_ext;

	// all distances stay inside the 22 bit range for 21 bit positions
	always_comb begin
		upd.mode    = mode_cur;
		upd.phase   = phase_cur;
		upd.save_x  = 1'b0;
		upd.saved_x = item.x_position;
		res = '0;

		case (item.command)
			CMD_START: begin
				if (mode_cur == MODE_IDLE) begin
					if (cfg.depth != '0 && cfg.width != '0) begin
						upd.mode  = MODE_PAUSED;
						upd.phase = PH_SYNC;
					end else begin
						res.start_rejected = 1'b1;
					end
				end
			end
			CMD_STOP: begin
				if (mode_cur == MODE_PAUSED || mode_cur == MODE_ACTIVE) begin
					upd.mode  = MODE_IDLE;
					upd.phase = PH_IDLE;
				end
			end
			default: ;
		endcase

		// spindle gating between paused and active
		if (item.spindle_turning) begin
			if (upd.mode == MODE_PAUSED && !item.z_moving && !item.x_moving &&
				item.spindle_at_index) begin
				upd.mode = MODE_ACTIVE;
			end
		end else if (upd.mode == MODE_ACTIVE) begin
			upd.mode = MODE_PAUSED;
		end

		if (upd.mode == MODE_ACTIVE) begin
			unique case (upd.phase)
				PH_SYNC: begin
					upd.phase = PH_HOME_Z;
					res.sync_request = 1'b1;
				end
				PH_HOME_Z: begin
					if (!item.z_moving) begin
						if (z_off_home) begin
							res.move_valid    = 1'b1;
							res.move_distance = -z_ext;
							res.move_speed    = cfg.z_rapid;
						end else begin
							upd.phase = PH_HOME_X;
						end
					end
				end
				PH_HOME_X: begin
					if (!item.x_moving) begin
						if (x_off_home) begin
							res.move_valid    = 1'b1;
							res.move_axis     = 1'b1;
							res.move_distance = -x_ext;
							res.move_speed    = cfg.x_rapid;
						end else begin
							upd.phase = PH_PLUNGE;
						end
					end
				end
				PH_PLUNGE: begin
					res.move_valid          = 1'b1;
					res.move_distance       = -depth_ext;
					res.move_speed          = feed_spd;
					res.move_constant_speed = 1'b1;
					upd.phase = PH_BACKOFF;
				end
				PH_BACKOFF: begin
					if (!item.z_moving) begin
						upd.save_x        = 1'b1;
						res.move_valid    = 1'b1;
						res.move_axis     = 1'b1;
						res.move_distance = -DIST_W'(BACKOFF_UM);
						res.move_speed    = cfg.x_rapid;
						upd.phase = PH_RETRACT;
					end
				end
				PH_RETRACT: begin
					if (!item.x_moving) begin
						res.move_valid    = 1'b1;
						res.move_distance = -z_ext;
						res.move_speed    = cfg.z_rapid;
						upd.phase = PH_RESTORE;
					end
				end
				PH_RESTORE: begin
					if (!item.z_moving) begin
						res.move_valid    = 1'b1;
						res.move_axis     = 1'b1;
						res.move_distance = sx_ext - x_ext;
						res.move_speed    = cfg.x_rapid;
						upd.phase = PH_STEP_IN;
					end
				end
				PH_STEP_IN: begin
					if (!item.x_moving) begin
						res.move_valid = 1'b1;
						if (width_left) begin
							res.move_axis     = 1'b1;
							res.move_distance = (rem < step_ext) ? rem : step_ext;
							res.move_speed    = cfg.x_rapid;
							upd.phase = PH_REPLUNGE;
						end else begin
							res.move_distance       = -z_ext;
							res.move_speed          = half_feed_spd;
							res.move_constant_speed = 1'b1;
							upd.phase = PH_FINISH;
						end
					end
				end
				PH_REPLUNGE: begin
					if (!item.x_moving) begin
						res.move_valid          = 1'b1;
						res.move_distance       = -depth_ext;
						res.move_speed          = feed_spd;
						res.move_constant_speed = 1'b1;
						upd.phase = PH_BACKOFF;
					end
				end
				PH_FINISH: begin
					if (!item.z_moving) begin
						res.move_valid    = 1'b1;
						res.move_axis     = 1'b1;
						res.move_distance = -x_ext;
						res.move_speed    = cfg.x_rapid;
						upd.phase = PH_DONE;
					end
				end
				PH_DONE: begin
					upd.mode = MODE_IDLE;
				end
				default: ;
			endcase
		end

		res.run_mode    = upd.mode;
		res.cycle_phase = upd.phase;
	end

endmodule

// ----- hdl/boring_cycle_sequencer.sv -----
// Boring cycle sequencer. Each input word is one status tick: command, spindle
// flags, axis busy flags and Z/X positions in micrometres; each tick yields one
// output word with at most one relative move, the run mode and the cycle phase.
// A word is taken into an input register, worked through the phase logic and
// lands in the output register when that register is free or draining, and one
// word is accepted every cycle while the output side keeps taking words. The
// run mode, phase and saved X position update as each word moves into the
// output register. Configuration writes take effect on the next cycle and are
// meant to happen only while no tick is in flight.
module boring_cycle_sequencer import bcs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// command[1:0], spindle_turning, spindle_at_index, z_moving, x_moving,
	// z_position[20:0], x_position[20:0]
	input  logic [47:0]           s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// move_valid, move_axis, move_distance[21:0], move_speed[15:0],
	// move_constant_speed, sync_request, run_mode[1:0], cycle_phase[3:0],
	// start_rejected, zero fill [55:49]
	output logic [55:0]           m_tdata,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t                    cfg;
	item_t                   item_s1;
	logic                    valid_s1;
	result_t                 res_s2;
	logic                    valid_s2;
	logic [1:0]              mode_q;
	logic [3:0]              phase_q;
	logic signed [POS_W-1:0] saved_x_q;
	state_upd_t              upd;
	result_t                 res_nxt;
	logic                    adv;

	bcs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcs_phase_logic u_phase (
		.cfg         (cfg),
		.item        (item_s1),
		.mode_cur    (mode_q),
		.phase_cur   (phase_q),
		.saved_x_cur (saved_x_q),
		.upd         (upd),
		.res         (res_nxt)
	);

	// advance the input word when the output register is free or draining
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_t'(s_tdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			phase_q   <= PH_IDLE;
			saved_x_q <= '0;
		end else if (adv) begin
			mode_q  <= upd.mode;
			phase_q <= upd.phase;
			if (upd.save_x) begin
				saved_x_q <= upd.saved_x;
			end
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, res_s2};

`ifndef SYNTH
	// the held state always matches the mode and phase of the last word out
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (res_s2.run_mode == mode_q) && (res_s2.cycle_phase == phase_q))
		else $error("state registers disagree with last result");

	// a processed stop leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n)
		adv && (item_s1.command == CMD_STOP) |=> (mode_q == MODE_IDLE))
		else $error("stop did not return to idle");

	// an input word that cannot advance is held
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled input word lost");
`endif

endmodule
